// ----- rtl/bitmap_set_range_engine_core_assert.svh -----
// Assertion macros for the bitmap set/range engine.
// Included by rtl modules that carry concurrent checks; no dependencies.
`ifndef BITMAP_SET_RANGE_ENGINE_CORE_ASSERT_SVH
`define BITMAP_SET_RANGE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define BSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bsre_pkg.sv -----
// Package for the bitmap set/range engine: map geometry and operation codes.
// No dependencies.
package bsre_pkg;

    localparam int P_BITS   = 65536;
    localparam int P_WORD_W = 32;
    localparam int P_WORDS  = P_BITS / P_WORD_W;
    localparam int P_ADDR_W = $clog2(P_WORDS);
    localparam int P_POS_W  = 16;
    localparam int P_BIT_W  = $clog2(P_WORD_W);

    localparam logic [2:0] OP_TEST    = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_CLR     = 3'd2;
    localparam logic [2:0] OP_SET_RNG = 3'd3;
    localparam logic [2:0] OP_CLR_RNG = 3'd4;
    localparam logic [2:0] OP_OR_B    = 3'd5;
    localparam logic [2:0] OP_ANDN_B  = 3'd6;
    localparam logic [2:0] OP_AND_B   = 3'd7;

    typedef logic [P_WORD_W-1:0] t_word;
    typedef logic [P_ADDR_W-1:0] t_addr;

endpackage

// ----- rtl/bitmap_set_range_engine_core.sv -----
// Bitmap set/range engine top level: 2048 x 32 map in one synchronous RAM.
// Depends on bsre_pkg and bitmap_set_range_engine_core_assert.svh.
//
//  channel   | direction | handshake              | words
//  ----------+-----------+------------------------+-----------------------------------------
//  command   | in        | start && !busy         | operation, positions, byte index/value
//  result    | out       | o_done, one cycle      | bit_value
//
// Single-bit and byte operations go from accept through S_READ and S_WRITE to o_done (RAM read, then write).
// Range operations: each word spanned is a read then a write.
// A reversed range returns its result the cycle after accept.
// After reset the RAM is zeroed one word a cycle; busy stays high until all 2048 words are cleared.
// The result side cannot stall; o_done is a one-cycle strobe.
`include "bitmap_set_range_engine_core_assert.svh"

module bitmap_set_range_engine_core
    import bsre_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic [P_POS_W-1:0] i_first_position,
    input  logic [P_POS_W-1:0] i_last_position,
    input  logic [12:0]        i_byte_index,
    input  logic [7:0]         i_byte_value,
    output logic               o_done,
    output logic               o_bit_value
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]         r_state, n_state;
    t_addr              r_addr, n_addr;
    logic [2:0]         r_op;
    logic [P_POS_W-1:0] r_first, r_last;
    logic [1:0]         r_bidx;
    logic [7:0]         r_bval;
    logic               r_done, n_done;
    logic               r_bit, n_bit;

    t_word mem [P_WORDS];
    t_word r_rdata;
    logic  mem_we;
    t_word mem_wdata;

    logic   accept, reversed, is_range;
    t_addr  w_first, w_last;
    t_word  mask, bit_mask, byte_sh, byte_msk, new_word;
    logic [4:0] sh;

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_bit_value = r_bit;
    assign accept      = start && !busy;
    assign reversed    = (i_last_position < i_first_position);
    assign is_range    = (r_op == OP_SET_RNG) || (r_op == OP_CLR_RNG);
    assign w_first     = r_first[P_POS_W-1:P_BIT_W];
    assign w_last      = r_last[P_POS_W-1:P_BIT_W];

    always_comb begin
        mask = '1;
        if (r_addr == w_first) begin
            mask = mask & ('1 << r_first[P_BIT_W-1:0]);
        end
        if (r_addr == w_last) begin
            mask = mask & ('1 >> (~r_last[P_BIT_W-1:0]));
        end
        bit_mask = t_word'(1) << r_first[P_BIT_W-1:0];
        sh       = {r_bidx, 3'b000};
        byte_sh  = t_word'(r_bval) << sh;
        byte_msk = t_word'(8'hFF) << sh;
        unique case (r_op)
            OP_SET:     new_word = r_rdata | bit_mask;
            OP_CLR:     new_word = r_rdata & ~bit_mask;
            OP_SET_RNG: new_word = r_rdata | mask;
            OP_CLR_RNG: new_word = r_rdata & ~mask;
            OP_OR_B:    new_word = r_rdata | byte_sh;
            OP_ANDN_B:  new_word = r_rdata & ~byte_sh;
            OP_AND_B:   new_word = r_rdata & ~(byte_msk & ~byte_sh);
            default:    new_word = r_rdata;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_done    = 1'b0;
        n_bit     = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + t_addr'(1);
                if (r_addr == t_addr'(P_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if ((i_operation == OP_SET_RNG || i_operation == OP_CLR_RNG) && reversed) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = S_READ;
                        if (i_operation == OP_OR_B || i_operation == OP_ANDN_B
                                || i_operation == OP_AND_B) begin
                            n_addr = i_byte_index[12:2];
                        end else begin
                            n_addr = i_first_position[P_POS_W-1:P_BIT_W];
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                mem_we    = (r_op != OP_TEST);
                mem_wdata = new_word;
                if (is_range && (r_addr != w_last)) begin
                    n_addr  = r_addr + t_addr'(1);
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_bit   = (r_op == OP_TEST) && r_rdata[r_first[P_BIT_W-1:0]];
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_done  <= 1'b0;
            r_bit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_done  <= n_done;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_first <= i_first_position;
            r_last  <= i_last_position;
            r_bidx  <= i_byte_index[1:0];
            r_bval  <= i_byte_value;
        end
    end

    // word RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    `BSR_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "strobe outside idle")
    `BSR_ASSERT_IMP(a_range_bounds, i_clk, i_rst_n, (r_state == S_WRITE) && is_range,
        (r_addr >= w_first) && (r_addr <= w_last), "range walk out of bounds")
    `BSR_ASSERT_IMP(a_bit_test_only, i_clk, i_rst_n, r_done && (r_op != OP_TEST), !r_bit,
        "bit set on non-test result")
    `BSR_ASSERT_NXT(a_clear_busy, i_clk, i_rst_n, (r_state == S_CLEAR) && (r_addr != '1),
        busy && !r_done, "clear pass interrupted")

endmodule
